// ===== rtl/core/pal_pkg.sv =====
// Package: widths, codes and controller/datapath structs for the positional array list.
package pal_pkg;

  localparam int unsigned DEPTH   = 16;
  localparam int unsigned KEY_W   = 32;
  localparam int unsigned POS_W   = 5;
  localparam int unsigned IDX_W   = 4;
  localparam int unsigned CNT_W   = 5;
  localparam int unsigned OP_W    = 2;
  localparam int unsigned STAT_W  = 3;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_SEARCH = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_RANGE   = 3'd3,
    ST_MISSING = 3'd4
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_HOLD = 1'b1
  } state_e;

  typedef struct packed {
    logic    load;
    logic    insert;
    logic    remove;
    logic    search_ok;
    status_e status;
  } pal_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic pos_le_cnt;
    logic pos_lt_cnt;
    logic hit;
  } pal_stat_t;

endpackage

// ===== rtl/core/pal_in_if.sv =====
// Input channel interface: operation, position and key with valid/ready.
interface pal_in_if
  import pal_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  operation;
  logic [POS_W-1:0] position;
  logic [KEY_W-1:0] key;

  modport source (output valid, output operation, output position, output key, input ready);
  modport sink   (input valid, input operation, input position, input key, output ready);
endinterface

// ===== rtl/core/pal_out_if.sv =====
// Output channel interface: status, removed key, match index and count with valid/ready.
interface pal_out_if
  import pal_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [KEY_W-1:0]  key_out;
  logic [IDX_W-1:0]  index_out;
  logic [CNT_W-1:0]  count_out;

  modport source (output valid, output status, output key_out, output index_out,
                  output count_out, input ready);
  modport sink   (input valid, input status, input key_out, input index_out,
                  input count_out, output ready);
endinterface

// ===== rtl/core/pal_ctrl.sv =====
// Controller: handshake state machine and operation decode into datapath commands.
module pal_ctrl
  import pal_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [OP_W-1:0] operation_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  pal_stat_t       stat_i,
  output pal_cmd_t        cmd_o
);

  state_e state_q, state_d;
  logic   accept;
  op_e    op;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    op          = op_e'(operation_i);
    in_ready_o  = (state_q == S_IDLE) || out_ready_i;
    out_valid_o = (state_q == S_HOLD);
    accept      = in_valid_i && in_ready_o;

    state_d = state_q;
    if (accept) begin
      state_d = S_HOLD;
    end else if (out_ready_i) begin
      state_d = S_IDLE;
    end

    cmd_o           = '0;
    cmd_o.load      = accept;
    cmd_o.status    = ST_OK;
    case (op)
      OP_INSERT: begin
        if (stat_i.full) begin
          cmd_o.status = ST_FULL;
        end else if (!stat_i.pos_le_cnt) begin
          cmd_o.status = ST_RANGE;
        end else begin
          cmd_o.insert = accept;
        end
      end
      OP_REMOVE: begin
        if (stat_i.empty) begin
          cmd_o.status = ST_EMPTY;
        end else if (!stat_i.pos_lt_cnt) begin
          cmd_o.status = ST_RANGE;
        end else begin
          cmd_o.remove = accept;
        end
      end
      OP_SEARCH: begin
        if (stat_i.empty) begin
          cmd_o.status = ST_EMPTY;
        end else if (!stat_i.hit) begin
          cmd_o.status = ST_MISSING;
        end else begin
          cmd_o.search_ok = 1'b1;
        end
      end
      default: begin
        cmd_o.status = ST_OK;
      end
    endcase
  end

endmodule

// ===== rtl/core/pal_dp.sv =====
// Datapath: entry cells with parallel shift and compare, count and result registers.
module pal_dp
  import pal_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [POS_W-1:0]  position_i,
  input  logic [KEY_W-1:0]  key_i,
  input  pal_cmd_t          cmd_i,
  output pal_stat_t         stat_o,
  output logic [STAT_W-1:0] status_o,
  output logic [KEY_W-1:0]  key_out_o,
  output logic [IDX_W-1:0]  index_out_o,
  output logic [CNT_W-1:0]  count_out_o
);

  logic [KEY_W-1:0]  cell_q [DEPTH];
  logic [KEY_W-1:0]  cell_d [DEPTH];
  logic [CNT_W-1:0]  count_q, count_d;
  logic [DEPTH-1:0]  match;
  logic [IDX_W-1:0]  hit_idx;
  logic [STAT_W-1:0] status_q;
  logic [KEY_W-1:0]  key_out_q;
  logic [IDX_W-1:0]  index_out_q;
  logic [CNT_W-1:0]  count_out_q;

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      match[i] = (CNT_W'(i) < count_q) && (cell_q[i] == key_i);
    end
    hit_idx = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_idx = IDX_W'(i);
      end
    end

    stat_o.full       = (count_q == CNT_W'(DEPTH));
    stat_o.empty      = (count_q == '0);
    stat_o.pos_le_cnt = (position_i <= count_q);
    stat_o.pos_lt_cnt = (position_i < count_q);
    stat_o.hit        = |match;

    for (int i = 0; i < DEPTH; i++) begin
      cell_d[i] = cell_q[i];
      if (cmd_i.insert) begin
        if (POS_W'(i) == position_i) begin
          cell_d[i] = key_i;
        end else if (i > 0 && POS_W'(i) > position_i && CNT_W'(i) <= count_q) begin
          cell_d[i] = cell_q[(i > 0) ? i - 1 : 0];
        end
      end else if (cmd_i.remove) begin
        if (i < DEPTH - 1 && POS_W'(i) >= position_i && CNT_W'(i + 1) < count_q) begin
          cell_d[i] = cell_q[(i < DEPTH - 1) ? i + 1 : i];
        end
      end
    end

    count_d = count_q;
    if (cmd_i.insert) begin
      count_d = count_q + CNT_W'(1);
    end else if (cmd_i.remove) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < DEPTH; i++) begin
      cell_q[i] <= cell_d[i];
    end
    if (cmd_i.load) begin
      status_q    <= cmd_i.status;
      key_out_q   <= cmd_i.remove ? cell_q[position_i[IDX_W-1:0]] : '0;
      index_out_q <= cmd_i.search_ok ? hit_idx : '0;
      count_out_q <= count_d;
    end
  end

  assign status_o    = status_q;
  assign key_out_o   = key_out_q;
  assign index_out_o = index_out_q;
  assign count_out_o = count_out_q;

endmodule

// ===== rtl/core/positional_array_list.sv =====
// Top level: positional array list with insert, remove and search over 16 keys.
//
// Usage:
//   in_i carries operation, position and key; a transaction completes when
//   valid and ready are both high at a rising clock edge. out_o carries
//   status, key_out, index_out and count_out, one result per transaction.
//   Insert shifts later entries up, remove shifts them down and returns the
//   removed key, search compares every stored entry in parallel and returns
//   the first match.
//   Latency: the result is valid the cycle after the input transaction.
//   Throughput: one transaction per cycle while out ready is high; every entry cell shifts and every
//   comparator evaluates in the same cycle, and the result register takes a
//   new result in the cycle the previous one is taken.
//   Stall: while a result waits and out ready is low, in ready is low and
//   the list holds its contents.
//   Reset: rst_ni clears the count and the output valid; entry cells are
//   not cleared, only entries below the count are ever read.
module positional_array_list
  import pal_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  pal_in_if.sink   in_i,
  pal_out_if.source out_o
);

  pal_cmd_t  cmd;
  pal_stat_t stat;

  pal_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .operation_i (in_i.operation),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  pal_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .position_i  (in_i.position),
    .key_i       (in_i.key),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .status_o    (out_o.status),
    .key_out_o   (out_o.key_out),
    .index_out_o (out_o.index_out),
    .count_out_o (out_o.count_out)
  );

endmodule

// ===== tb/sv/tb.sv =====
// Testbench for positional_array_list: directed and random insert/remove/search traffic checked against a list model.
module tb;
  import pal_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1900;
  localparam int unsigned STALL_PCT    = 27;
  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 4;

  typedef struct packed {
    status_e          status;
    logic [KEY_W-1:0] key;
    logic [IDX_W-1:0] index;
    logic [CNT_W-1:0] count;
  } list_result_t;

  class list_scoreboard;
    logic [KEY_W-1:0] cells [DEPTH];
    int unsigned      used;
    list_result_t     result_q [$];
    int unsigned      failures;
    int unsigned      checked;
    int unsigned      status_hits [5];

    function new();
      used     = 0;
      failures = 0;
      checked  = 0;
      foreach (status_hits[i]) status_hits[i] = 0;
    endfunction

    function void note_op(logic [OP_W-1:0] op, logic [POS_W-1:0] pos, logic [KEY_W-1:0] key);
      list_result_t r;
      bit           hit;
      r.status = ST_OK;
      r.key    = '0;
      r.index  = '0;
      hit      = 1'b0;
      case (op)
        OP_INSERT: begin
          if (used >= DEPTH) begin
            r.status = ST_FULL;
          end else if (pos > used) begin
            r.status = ST_RANGE;
          end else begin
            for (int i = used; i > pos; i--) cells[i] = cells[i-1];
            cells[pos] = key;
            used++;
          end
        end
        OP_REMOVE: begin
          if (used == 0) begin
            r.status = ST_EMPTY;
          end else if (pos >= used) begin
            r.status = ST_RANGE;
          end else begin
            r.key = cells[pos];
            for (int i = pos; i + 1 < used; i++) cells[i] = cells[i+1];
            used--;
          end
        end
        OP_SEARCH: begin
          if (used == 0) begin
            r.status = ST_EMPTY;
          end else begin
            for (int i = 0; i < used; i++) begin
              if (!hit && cells[i] == key) begin
                hit     = 1'b1;
                r.index = IDX_W'(i);
              end
            end
            if (!hit) r.status = ST_MISSING;
          end
        end
        default: ;
      endcase
      r.count = CNT_W'(used);
      status_hits[int'(r.status)]++;
      result_q.push_back(r);
    endfunction

    function void check_result(logic [STAT_W-1:0] st, logic [KEY_W-1:0] k,
                               logic [IDX_W-1:0] idx, logic [CNT_W-1:0] cnt);
      list_result_t want;
      if (result_q.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("tb: result with nothing pending: status=%0d key=%h index=%0d count=%0d",
                   st, k, idx, cnt);
        return;
      end
      want = result_q.pop_front();
      checked++;
      if (st !== want.status || k !== want.key || idx !== want.index || cnt !== want.count) begin
        failures++;
        if (failures <= 10)
          $display("tb: mismatch #%0d: exp status=%0d key=%h index=%0d count=%0d, got status=%0d key=%h index=%0d count=%0d",
                   checked, want.status, want.key, want.index, want.count, st, k, idx, cnt);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  pal_in_if  in_bus ();
  pal_out_if out_bus ();

  positional_array_list dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  list_scoreboard sb = new();
  bit             idle_on = 1'b1;
  int unsigned    quiet_cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  task automatic run_op(logic [OP_W-1:0] op, logic [POS_W-1:0] pos, logic [KEY_W-1:0] key);
    int unsigned gap;
    gap = 0;
    if (idle_on) while ($urandom_range(99) < STALL_PCT) gap++;
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_bus.valid     <= 1'b1;
    in_bus.operation <= op;
    in_bus.position  <= pos;
    in_bus.key       <= key;
    do @(posedge clk_i); while (!in_bus.ready);
    sb.note_op(op, pos, key);
  endtask

  task automatic fill_list();
    while (sb.used < DEPTH) run_op(OP_INSERT, POS_W'($urandom_range(0, sb.used)), $urandom);
  endtask

  // result side: check, then pick ready for the next edge
  initial begin
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_bus.valid && out_bus.ready)
        sb.check_result(out_bus.status, out_bus.key_out, out_bus.index_out, out_bus.count_out);
      out_bus.ready <= idle_on ? ($urandom_range(99) >= STALL_PCT) : 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb: watchdog expired after %0d idle cycles", quiet_cycles);
        $display("tb: done, errors");
        $finish;
      end
    end
  end

  initial begin
    logic [OP_W-1:0]  op;
    logic [POS_W-1:0] pos;
    logic [KEY_W-1:0] key;
    int unsigned      grow;
    int unsigned      pick;
    int unsigned      ins_w;
    int unsigned      rem_w;

    rst_ni           <= 1'b0;
    in_bus.valid     <= 1'b0;
    in_bus.operation <= OP_NONE;
    in_bus.position  <= '0;
    in_bus.key       <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty list, bounds, head/middle/tail, duplicates, full list
    run_op(OP_SEARCH, 5'd0, 32'h0);
    run_op(OP_REMOVE, 5'd0, 32'h0);
    run_op(OP_NONE,   5'd31, 32'hFFFF_FFFF);
    run_op(OP_INSERT, 5'd1, 32'h1);
    run_op(OP_INSERT, 5'd0, 32'h0);
    run_op(OP_INSERT, 5'd1, 32'hFFFF_FFFF);
    run_op(OP_INSERT, 5'd1, 32'h5);
    run_op(OP_INSERT, 5'd0, 32'h5);
    run_op(OP_SEARCH, 5'd0, 32'h5);
    run_op(OP_SEARCH, 5'd0, 32'hFFFF_FFFF);
    run_op(OP_SEARCH, 5'd0, 32'h1234_5678);
    run_op(OP_REMOVE, 5'd4, 32'h0);
    run_op(OP_REMOVE, 5'd31, 32'h0);
    run_op(OP_REMOVE, 5'd1, 32'h0);
    run_op(OP_REMOVE, 5'd2, 32'h0);
    fill_list();
    run_op(OP_INSERT, 5'd0, 32'hA5A5_A5A5);
    run_op(OP_INSERT, 5'd31, 32'h5A5A_5A5A);
    run_op(OP_SEARCH, 5'd0, sb.cells[DEPTH-1]);
    run_op(OP_REMOVE, 5'd16, 32'h0);
    run_op(OP_REMOVE, 5'd15, 32'h0);
    run_op(OP_NONE,   5'd16, 32'h0);

    grow = 1;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 120 == 0) grow = $urandom_range(2);
      idle_on = !(n >= 700 && n < 1000);
      if (n == 1300) begin
        in_bus.valid <= 1'b0;
        do @(posedge clk_i); while (sb.result_q.size() != 0);
      end
      ins_w = (grow == 2) ? 55 : (grow == 0) ? 20 : 38;
      rem_w = (grow == 0) ? 55 : (grow == 2) ? 20 : 38;
      pick  = $urandom_range(99);
      key   = ($urandom_range(3) == 0) ? KEY_W'($urandom_range(7)) : $urandom;
      if ($urandom_range(99) < 4) begin
        op  = OP_W'($urandom_range(3));
        pos = POS_W'($urandom_range(31));
      end else if (pick < ins_w) begin
        op  = OP_INSERT;
        pos = ($urandom_range(9) == 0) ? POS_W'($urandom_range(31))
                                       : POS_W'($urandom_range(0, sb.used));
      end else if (pick < ins_w + rem_w) begin
        op  = OP_REMOVE;
        pos = (sb.used > 0 && $urandom_range(9) != 0) ? POS_W'($urandom_range(0, sb.used - 1))
                                                     : POS_W'($urandom_range(31));
      end else begin
        op  = OP_SEARCH;
        pos = POS_W'($urandom_range(31));
        if (sb.used > 0 && $urandom_range(2) != 0) key = sb.cells[$urandom_range(0, sb.used - 1)];
      end
      run_op(op, pos, key);
    end

    in_bus.valid <= 1'b0;
    idle_on = 1'b1;
    while (sb.result_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("tb: %0d results checked; ok %0d, full %0d, empty %0d, bad position %0d, no match %0d",
             sb.checked, sb.status_hits[0], sb.status_hits[1], sb.status_hits[2],
             sb.status_hits[3], sb.status_hits[4]);
    $display("tb: %0d failures", sb.failures);
    if (sb.failures == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
